// ===== rtl/fbve_pkg.sv =====
// Field bit vector encoder: shared types, constants and helper functions.
// No dependencies; every other file takes names from here by scope.
package fbve_pkg;

    localparam int PORTS      = 4;
    localparam int VAL_W      = 16;
    localparam int SETUP_W    = 39;
    localparam int IDX_W      = 3;
    localparam int EXP_W      = 4;
    localparam int FC_W       = 3;
    localparam int OB_W       = 9;
    localparam int WORD_W     = 64;
    localparam int P_W        = 6;
    localparam int SB_W       = 5;
    localparam int LEN_RAW_W  = 17;

    typedef enum logic [2:0] {
        ENC_LITERAL    = 3'd0,
        ENC_GRAY       = 3'd1,
        ENC_THERMO     = 3'd2,
        ENC_LOG_THERMO = 3'd3,
        ENC_ONE_HOT    = 3'd4
    } t_enc;

    localparam logic [IDX_W-1:0] REG_FIELD_COUNT  = 3'd0;
    localparam logic [IDX_W-1:0] REG_OUTPUT_BITS  = 3'd1;
    localparam logic [IDX_W-1:0] REG_FIELD0_SETUP = 3'd2;

    localparam logic [FC_W-1:0]    FIELD_COUNT_RST = 3'd1;
    localparam logic [OB_W-1:0]    OUTPUT_BITS_RST = 9'd256;
    localparam logic [SETUP_W-1:0] SETUP_RST       = 39'h08_0001_0000;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_PREP = 2'd1,
        S_GEN  = 2'd2
    } t_state;

    typedef struct packed {
        logic start;
        logic prep;
        logic gen;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic prep_last;
        logic word_full;
        logic out_free;
        logic vec_done;
    } t_status;

    // number of significant bits, zero for zero
    function automatic logic [SB_W-1:0] sig_bits(input logic [VAL_W-1:0] x);
        logic [SB_W-1:0] b;
        b = '0;
        for (int i = 0; i < VAL_W; i++) begin
            if (x[i]) begin
                b = SB_W'(i + 1);
            end
        end
        return b;
    endfunction

    function automatic logic code_bit(input t_enc enc, input logic [VAL_W-1:0] val,
                                      input logic [P_W-1:0] p);
        logic [VAL_W-1:0] pe;
        logic             b;
        pe = VAL_W'(p);
        case (enc)
            ENC_ONE_HOT: begin
                b = (pe == val);
            end
            ENC_THERMO, ENC_LOG_THERMO: begin
                b = (pe < val);
            end
            default: begin
                b = (p < P_W'(VAL_W)) ? val[p[3:0]] : 1'b0;
            end
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/fbve_if.sv =====
// Field bit vector encoder: valid/ready channel interfaces.
// Depends on fbve_pkg for payload widths.
interface fbve_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [fbve_pkg::VAL_W-1:0] value_0;
    logic signed [fbve_pkg::VAL_W-1:0] value_1;
    logic signed [fbve_pkg::VAL_W-1:0] value_2;
    logic signed [fbve_pkg::VAL_W-1:0] value_3;

    modport source (output valid, value_0, value_1, value_2, value_3, input ready);
    modport sink   (input valid, value_0, value_1, value_2, value_3, output ready);
endinterface

interface fbve_out_if;
    logic                        valid;
    logic                        ready;
    logic [fbve_pkg::WORD_W-1:0] word;
    logic                        last;
    logic                        range_error;

    modport source (output valid, word, last, range_error, input ready);
    modport sink   (input valid, word, last, range_error, output ready);
endinterface

interface fbve_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [fbve_pkg::IDX_W-1:0]   index;
    logic [fbve_pkg::SETUP_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/fbve_cfg_regs.sv =====
// Field bit vector encoder: configuration register file.
// Depends on fbve_pkg and fbve_cfg_if.
module fbve_cfg_regs (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    fbve_cfg_if.sink                                      i_cfg,
    output logic [fbve_pkg::FC_W-1:0]                     o_field_count,
    output logic [fbve_pkg::OB_W-1:0]                     o_output_bits,
    output logic [fbve_pkg::PORTS-1:0][fbve_pkg::SETUP_W-1:0] o_setup
);

    logic [fbve_pkg::FC_W-1:0]                         r_field_count;
    logic [fbve_pkg::OB_W-1:0]                         r_output_bits;
    logic [fbve_pkg::PORTS-1:0][fbve_pkg::SETUP_W-1:0] r_setup;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_count <= fbve_pkg::FIELD_COUNT_RST;
            r_output_bits <= fbve_pkg::OUTPUT_BITS_RST;
            for (int i = 0; i < fbve_pkg::PORTS; i++) begin
                r_setup[i] <= fbve_pkg::SETUP_RST;
            end
        end else if (i_cfg.valid) begin
            if (i_cfg.index == fbve_pkg::REG_FIELD_COUNT) begin
                r_field_count <= i_cfg.data[fbve_pkg::FC_W-1:0];
            end
            if (i_cfg.index == fbve_pkg::REG_OUTPUT_BITS) begin
                r_output_bits <= i_cfg.data[fbve_pkg::OB_W-1:0];
            end
            for (int i = 0; i < fbve_pkg::PORTS; i++) begin
                if (i_cfg.index == fbve_pkg::IDX_W'(fbve_pkg::REG_FIELD0_SETUP + i)) begin
                    r_setup[i] <= i_cfg.data;
                end
            end
        end
    end

    assign o_field_count = r_field_count;
    assign o_output_bits = r_output_bits;
    assign o_setup       = r_setup;

endmodule

// ===== rtl/fbve_ctrl.sv =====
// Field bit vector encoder: sequencing state machine.
// Depends on fbve_pkg (state, command and status types).
module fbve_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  fbve_pkg::t_status i_status,
    output fbve_pkg::t_cmd    o_cmd
);

    fbve_pkg::t_state r_state;
    fbve_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fbve_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            fbve_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = fbve_pkg::S_PREP;
                end
            end
            fbve_pkg::S_PREP: begin
                if (i_status.prep_last) begin
                    n_state = fbve_pkg::S_GEN;
                end
            end
            fbve_pkg::S_GEN: begin
                if (i_status.word_full && i_status.out_free && i_status.vec_done) begin
                    n_state = fbve_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fbve_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            fbve_pkg::S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.start = i_in_valid;
            end
            fbve_pkg::S_PREP: begin
                o_cmd.prep = 1'b1;
            end
            fbve_pkg::S_GEN: begin
                o_cmd.gen  = !i_status.word_full;
                o_cmd.load = i_status.word_full && i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/fbve_dp.sv =====
// Field bit vector encoder: field prep, bit interleaver and output register.
// Depends on fbve_pkg; driven by fbve_ctrl commands.
module fbve_dp #(
    parameter int NUM_FIELDS          = 4,
    parameter int MAX_OUT_BITS        = 256,
    parameter int MAX_FIELD_CODE_BITS = 64
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  fbve_pkg::t_cmd                                    i_cmd,
    output fbve_pkg::t_status                                 o_status,
    input  logic [fbve_pkg::PORTS-1:0][fbve_pkg::VAL_W-1:0]   i_values,
    input  logic [fbve_pkg::FC_W-1:0]                         i_field_count,
    input  logic [fbve_pkg::OB_W-1:0]                         i_output_bits,
    input  logic [fbve_pkg::PORTS-1:0][fbve_pkg::SETUP_W-1:0] i_setup,
    input  logic                                              i_out_ready,
    output logic                                              o_out_valid,
    output logic [fbve_pkg::WORD_W-1:0]                       o_word,
    output logic                                              o_last,
    output logic                                              o_range_error
);

    localparam int FIELDS = (NUM_FIELDS < fbve_pkg::PORTS) ? NUM_FIELDS : fbve_pkg::PORTS;
    localparam int PW     = (FIELDS > 1) ? $clog2(FIELDS) : 1;
    localparam int CW     = $clog2(MAX_OUT_BITS + 1);
    localparam int OBW    = (CW > fbve_pkg::OB_W) ? CW : fbve_pkg::OB_W;
    localparam int LW     = $clog2(MAX_FIELD_CODE_BITS + 1);
    localparam int VW     = fbve_pkg::VAL_W;
    localparam int EW     = fbve_pkg::EXP_W;

    // per-transaction state
    logic [FIELDS-1:0][VW-1:0]  r_vin;
    logic [PW-1:0]              r_nf_m1;
    logic [CW-1:0]              r_nbits;
    logic [PW-1:0]              r_pidx;
    logic                       r_err;
    logic [EW-1:0]              r_maxexp;
    logic                       r_nonzero;
    fbve_pkg::t_enc             r_enc   [FIELDS];
    logic [VW-1:0]              r_cval  [FIELDS];
    logic [LW-1:0]              r_len   [FIELDS];
    logic [LW-1:0]              r_pos   [FIELDS];
    logic [EW-1:0]              r_exp   [FIELDS];
    logic [PW-1:0]              r_fptr;
    logic [EW-1:0]              r_level;
    logic                       r_any;
    logic [CW-1:0]              r_count;
    logic [fbve_pkg::WORD_W-1:0] r_acc;
    logic                       r_word_full;
    logic                       r_vec_last;
    logic                       r_out_valid;
    logic [fbve_pkg::WORD_W-1:0] r_out_word;
    logic                       r_out_last;
    logic                       r_out_err;

    // transaction start
    logic [PW-1:0]  n_nf_m1;
    logic [OBW-1:0] nb_ext;
    logic [CW-1:0]  n_nbits;

    always_comb begin
        if (i_field_count == '0) begin
            n_nf_m1 = '0;
        end else if (int'(i_field_count) > FIELDS) begin
            n_nf_m1 = PW'(FIELDS - 1);
        end else begin
            n_nf_m1 = PW'(i_field_count - 1'b1);
        end
        nb_ext = OBW'(i_output_bits);
        if (nb_ext == '0) begin
            n_nbits = CW'(1);
        end else if (nb_ext > OBW'(MAX_OUT_BITS)) begin
            n_nbits = CW'(MAX_OUT_BITS);
        end else begin
            n_nbits = CW'(nb_ext);
        end
    end

    // field prep, one field a cycle
    logic [FIELDS-1:0][fbve_pkg::SETUP_W-1:0] setup_f;
    logic [fbve_pkg::SETUP_W-1:0]             setup;
    logic signed [VW-1:0]                     lo, hi, hi_eff, v, vc;
    logic [fbve_pkg::LEN_RAW_W-1:0]           rng17, off17, len_raw;
    logic [VW-1:0]                            rng, off;
    fbve_pkg::t_enc                           enc;
    logic                                     thermo, v_hi, v_lo, err_f;
    logic [VW-1:0]                            n_cval;
    logic [LW-1:0]                            n_len;
    logic [EW-1:0]                            n_exp;

    always_comb begin
        for (int i = 0; i < FIELDS; i++) begin
            setup_f[i] = i_setup[i];
        end
        setup  = setup_f[r_pidx];
        lo     = setup[15:0];
        hi     = setup[31:16];
        hi_eff = (hi < lo) ? lo : hi;
        v      = r_vin[r_pidx];
        rng17  = {hi_eff[VW-1], hi_eff} - {lo[VW-1], lo};
        rng    = rng17[VW-1:0];
        if (setup[34:32] > fbve_pkg::ENC_ONE_HOT) begin
            enc = fbve_pkg::ENC_LITERAL;
        end else begin
            enc = fbve_pkg::t_enc'(setup[34:32]);
        end
        thermo = (enc == fbve_pkg::ENC_THERMO) || (enc == fbve_pkg::ENC_LOG_THERMO);
        v_hi   = (v > hi_eff);
        v_lo   = (v < lo);
        vc     = v_hi ? hi_eff : (v_lo ? lo : v);
        err_f  = (v_hi && !thermo) || v_lo;
        off17  = {vc[VW-1], vc} - {lo[VW-1], lo};
        off    = off17[VW-1:0];
        case (enc)
            fbve_pkg::ENC_GRAY: begin
                n_cval  = off ^ (off >> 1);
                len_raw = fbve_pkg::LEN_RAW_W'(fbve_pkg::sig_bits(rng));
            end
            fbve_pkg::ENC_THERMO: begin
                n_cval  = off;
                len_raw = {1'b0, rng};
            end
            fbve_pkg::ENC_LOG_THERMO: begin
                n_cval  = VW'(fbve_pkg::sig_bits(off));
                len_raw = fbve_pkg::LEN_RAW_W'(fbve_pkg::sig_bits(rng));
            end
            fbve_pkg::ENC_ONE_HOT: begin
                n_cval  = off;
                len_raw = {1'b0, rng} + 1'b1;
            end
            default: begin
                n_cval  = off;
                len_raw = fbve_pkg::LEN_RAW_W'(fbve_pkg::sig_bits(rng));
            end
        endcase
        if (len_raw > fbve_pkg::LEN_RAW_W'(MAX_FIELD_CODE_BITS)) begin
            n_len = LW'(MAX_FIELD_CODE_BITS);
        end else begin
            n_len = LW'(len_raw);
        end
        n_exp = (setup[38:35] == '0) ? EW'(1) : setup[38:35];
    end

    // interleaver slot for field r_fptr
    logic                   elig, code, emit, round_end, any_round;
    logic [LW-1:0]          pos_m1;
    logic [CW-1:0]          cnt_next;
    logic [EW-1:0]          level_next;

    always_comb begin
        elig       = (r_exp[r_fptr] >= r_level) && (r_pos[r_fptr] != '0);
        pos_m1     = r_pos[r_fptr] - 1'b1;
        code       = fbve_pkg::code_bit(r_enc[r_fptr], r_cval[r_fptr],
                                        fbve_pkg::P_W'(pos_m1));
        emit       = !r_nonzero || elig;
        cnt_next   = CW'(r_count + 1'b1);
        round_end  = (r_fptr == r_nf_m1);
        any_round  = r_any || elig;
        level_next = (r_level == r_maxexp) ? EW'(1) : EW'(r_level + 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_full <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                for (int i = 0; i < FIELDS; i++) begin
                    r_vin[i] <= i_values[i];
                end
                r_nf_m1     <= n_nf_m1;
                r_nbits     <= n_nbits;
                r_pidx      <= '0;
                r_err       <= 1'b0;
                r_maxexp    <= EW'(1);
                r_nonzero   <= 1'b0;
                r_fptr      <= '0;
                r_level     <= EW'(1);
                r_any       <= 1'b0;
                r_count     <= '0;
                r_acc       <= '0;
                r_word_full <= 1'b0;
                r_vec_last  <= 1'b0;
            end
            if (i_cmd.prep) begin
                r_enc[r_pidx]  <= enc;
                r_cval[r_pidx] <= n_cval;
                r_len[r_pidx]  <= n_len;
                r_pos[r_pidx]  <= n_len;
                r_exp[r_pidx]  <= n_exp;
                r_err          <= r_err || err_f;
                if (n_exp > r_maxexp) begin
                    r_maxexp <= n_exp;
                end
                if (n_len != '0) begin
                    r_nonzero <= 1'b1;
                end
                r_pidx <= PW'(r_pidx + 1'b1);
            end
            if (i_cmd.gen) begin
                if (emit) begin
                    r_acc[r_count[5:0]] <= code && r_nonzero;
                    r_count             <= cnt_next;
                    r_vec_last          <= (cnt_next == r_nbits);
                    if ((r_count[5:0] == 6'd63) || (cnt_next == r_nbits)) begin
                        r_word_full <= 1'b1;
                    end
                end
                if (r_nonzero) begin
                    if (elig) begin
                        r_pos[r_fptr] <= pos_m1;
                    end
                    if (round_end) begin
                        r_fptr <= '0;
                        r_any  <= 1'b0;
                        if (!any_round) begin
                            r_level <= level_next;
                            for (int i = 0; i < FIELDS; i++) begin
                                r_pos[i] <= r_len[i];
                            end
                        end
                    end else begin
                        r_fptr <= PW'(r_fptr + 1'b1);
                        r_any  <= any_round;
                    end
                end
            end
            if (i_cmd.load) begin
                r_out_word  <= r_acc;
                r_out_last  <= r_vec_last;
                r_out_err   <= r_err;
                r_acc       <= '0;
                r_word_full <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.prep_last = (r_pidx == r_nf_m1);
    assign o_status.word_full = r_word_full;
    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_status.vec_done  = r_vec_last;

    assign o_out_valid   = r_out_valid;
    assign o_word        = r_out_word;
    assign o_last        = r_out_last;
    assign o_range_error = r_out_err;

endmodule

// ===== rtl/field_bit_vector_encoder.sv =====
// Field bit vector encoder: top level.
// Depends on fbve_pkg, fbve_if, fbve_cfg_regs, fbve_ctrl and fbve_dp.
//
// Channels: i_in carries one transaction of four signed 16-bit values;
// o_out returns the vector in 64-bit words, one or more per transaction, first vector
// bit in bit 0, with last set on the final word and range_error repeated on
// every word; i_cfg writes one register by index and is always ready.
// Sequence: the input is taken, then codes are prepared one field at a time
// for each field in use, then the interleaver visits one slot at a time. With
// every field still feeding the current pass and no full word waiting, one
// vector bit is produced per cycle; a slot for a field that has run out or sits
// below the pass level yields no bit, and a pass that yields no bit costs one
// round of slots. A full word, or one with the last bit, then moves to the output register.
// Throughput: one transaction at a time; a new input is taken once the last
// word has been moved into the output register, so input and output overlap.
// Receiver stall: the generator halts with a full word until the output
// register frees up; nothing is dropped.
// Reset: state returns to idle, output valid drops and the configuration registers take
// their reset values in the same cycle; there is no clearing pass.
module field_bit_vector_encoder #(
    parameter int NUM_FIELDS          = 4,
    parameter int MAX_OUT_BITS        = 256,
    parameter int MAX_FIELD_CODE_BITS = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fbve_in_if.sink      i_in,
    fbve_out_if.source   o_out,
    fbve_cfg_if.sink     i_cfg
);

    logic [fbve_pkg::FC_W-1:0]                         field_count;
    logic [fbve_pkg::OB_W-1:0]                         output_bits;
    logic [fbve_pkg::PORTS-1:0][fbve_pkg::SETUP_W-1:0] setup;
    logic [fbve_pkg::PORTS-1:0][fbve_pkg::VAL_W-1:0]   values;
    fbve_pkg::t_cmd                                    cmd;
    fbve_pkg::t_status                                 status;
    logic                                              in_ready;

    assign values[0]  = i_in.value_0;
    assign values[1]  = i_in.value_1;
    assign values[2]  = i_in.value_2;
    assign values[3]  = i_in.value_3;
    assign i_in.ready = in_ready;

    fbve_cfg_regs u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (i_cfg),
        .o_field_count (field_count),
        .o_output_bits (output_bits),
        .o_setup       (setup)
    );

    fbve_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    fbve_dp #(
        .NUM_FIELDS          (NUM_FIELDS),
        .MAX_OUT_BITS        (MAX_OUT_BITS),
        .MAX_FIELD_CODE_BITS (MAX_FIELD_CODE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_values      (values),
        .i_field_count (field_count),
        .i_output_bits (output_bits),
        .i_setup       (setup),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_word        (o_out.word),
        .o_last        (o_out.last),
        .o_range_error (o_out.range_error)
    );

endmodule

// ===== rtl/fbve_checker.sv =====
// Field bit vector encoder: port-level checker and its bind to the top level.
// Depends on field_bit_vector_encoder and fbve_pkg widths.
module fbve_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [fbve_pkg::WORD_W-1:0] i_out_word,
    input logic                        i_out_last,
    input logic                        i_out_range_error
);

    // held word must not change under backpressure
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_word)
            && $stable(i_out_last) && $stable(i_out_range_error))
        else $error("output word changed while stalled");

    // one transaction in flight
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted while busy");

    // when idle, only the final word of the previous vector can be pending
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready && i_out_valid |-> i_out_last)
        else $error("idle with a non-final word pending");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("reset did not return to idle");

endmodule

bind field_bit_vector_encoder fbve_checker u_fbve_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_word        (o_out.word),
    .i_out_last        (o_out.last),
    .i_out_range_error (o_out.range_error)
);

// ===== tb/tb.sv =====
// Testbench for field_bit_vector_encoder: directed and random transactions over
// many register settings, with a scoreboard that predicts every output word.
// Depends on fbve_pkg and the channel interfaces in fbve_if.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OUT_BITS_MAX   = 256;
    localparam int CODE_BITS_MAX  = 64;
    localparam int FIELDS_MAX     = 4;

    localparam logic [fbve_pkg::IDX_W-1:0] REG_SPARE_FIRST =
        fbve_pkg::REG_FIELD0_SETUP + fbve_pkg::IDX_W'(fbve_pkg::PORTS);
    localparam logic [2:0]       ENC_RSVD5       = 3'd5;
    localparam logic [2:0]       ENC_RSVD6       = 3'd6;
    localparam logic [2:0]       ENC_RSVD7       = 3'd7;

    typedef struct packed {
        logic [fbve_pkg::WORD_W-1:0] word;
        logic                        last;
        logic                        range_error;
    } t_word;

    class vector_scoreboard;
        logic [fbve_pkg::FC_W-1:0]    field_count;
        logic [fbve_pkg::OB_W-1:0]    output_bits;
        logic [fbve_pkg::SETUP_W-1:0] setup [fbve_pkg::PORTS];
        t_word                        expected_words [$];
        int                           errors;

        function new();
            field_count = fbve_pkg::FIELD_COUNT_RST;
            output_bits = fbve_pkg::OUTPUT_BITS_RST;
            foreach (setup[i]) setup[i] = fbve_pkg::SETUP_RST;
            errors = 0;
        endfunction

        task report(input string msg);
            if (errors < 100) begin
                $display("%0t: %s", $time, msg);
            end
            errors++;
        endtask

        function void write_reg(input logic [fbve_pkg::IDX_W-1:0] idx,
                                input logic [fbve_pkg::SETUP_W-1:0] data);
            if (idx == fbve_pkg::REG_FIELD_COUNT) begin
                field_count = data[fbve_pkg::FC_W-1:0];
            end else if (idx == fbve_pkg::REG_OUTPUT_BITS) begin
                output_bits = data[fbve_pkg::OB_W-1:0];
            end else if (idx >= fbve_pkg::REG_FIELD0_SETUP && idx < REG_SPARE_FIRST) begin
                setup[idx - fbve_pkg::REG_FIELD0_SETUP] = data;
            end
        endfunction

        // encodes one transaction into the bit vector and queues its words
        function void note_values(input logic [fbve_pkg::VAL_W-1:0] v0, v1, v2, v3);
            logic [fbve_pkg::VAL_W-1:0] raw [fbve_pkg::PORTS];
            fbve_pkg::t_enc             enc [fbve_pkg::PORTS];
            int unsigned                code [fbve_pkg::PORTS];
            int                         len [fbve_pkg::PORTS];
            int                         expn [fbve_pkg::PORTS];
            int                         pos [fbve_pkg::PORTS];
            logic [OUT_BITS_MAX-1:0]    vec;
            logic [2:0]                 e3;
            t_word                      w;
            int                         nf, nbits, cnt, level, maxexp, total, nwords;
            int                         lo, hi, v, r;
            bit                         err, any, thermo, bitv;
            raw = '{v0, v1, v2, v3};
            nf = field_count;
            if (nf < 1) nf = 1;
            if (nf > FIELDS_MAX) nf = FIELDS_MAX;
            nbits = output_bits;
            if (nbits < 1) nbits = 1;
            if (nbits > OUT_BITS_MAX) nbits = OUT_BITS_MAX;
            maxexp = 1;
            total = 0;
            err = 1'b0;
            for (int i = 0; i < nf; i++) begin
                lo = int'($signed(setup[i][15:0]));
                hi = int'($signed(setup[i][31:16]));
                v = int'($signed(raw[i]));
                e3 = setup[i][34:32];
                enc[i] = (e3 > fbve_pkg::ENC_ONE_HOT) ? fbve_pkg::ENC_LITERAL
                                                      : fbve_pkg::t_enc'(e3);
                expn[i] = int'(setup[i][38:35]);
                if (expn[i] == 0) expn[i] = 1;
                if (expn[i] > maxexp) maxexp = expn[i];
                if (hi < lo) hi = lo;
                r = hi - lo;
                thermo = (enc[i] == fbve_pkg::ENC_THERMO ||
                          enc[i] == fbve_pkg::ENC_LOG_THERMO);
                if (v > hi) begin
                    v = hi;
                    if (!thermo) err = 1'b1;
                end
                if (v < lo) begin
                    v = lo;
                    err = 1'b1;
                end
                code[i] = v - lo;
                case (enc[i])
                    fbve_pkg::ENC_THERMO:  len[i] = r;
                    fbve_pkg::ENC_ONE_HOT: len[i] = r + 1;
                    default:               len[i] = $clog2(r + 1);
                endcase
                if (len[i] > CODE_BITS_MAX) len[i] = CODE_BITS_MAX;
                if (enc[i] == fbve_pkg::ENC_GRAY) code[i] = code[i] ^ (code[i] >> 1);
                else if (enc[i] == fbve_pkg::ENC_LOG_THERMO) code[i] = $clog2(code[i] + 1);
                total += len[i];
            end
            vec = '0;
            if (total > 0) begin
                cnt = 0;
                level = 1;
                for (int i = 0; i < nf; i++) pos[i] = len[i];
                while (cnt < nbits) begin
                    any = 1'b0;
                    for (int i = 0; i < nf && cnt < nbits; i++) begin
                        if (expn[i] >= level && pos[i] > 0) begin
                            any = 1'b1;
                            pos[i]--;
                            case (enc[i])
                                fbve_pkg::ENC_ONE_HOT:
                                    bitv = (pos[i] == code[i]);
                                fbve_pkg::ENC_THERMO, fbve_pkg::ENC_LOG_THERMO:
                                    bitv = (pos[i] < code[i]);
                                default:
                                    bitv = code[i][pos[i] % 32] && pos[i] < 32;
                            endcase
                            vec[cnt] = bitv;
                            cnt++;
                        end
                    end
                    if (!any) begin
                        level++;
                        if (level > maxexp) level = 1;
                        for (int i = 0; i < nf; i++) pos[i] = len[i];
                    end
                end
            end
            nwords = (nbits + fbve_pkg::WORD_W - 1) / fbve_pkg::WORD_W;
            for (int k = 0; k < nwords; k++) begin
                w.word = vec[k*fbve_pkg::WORD_W +: fbve_pkg::WORD_W];
                w.last = (k == nwords - 1);
                w.range_error = err;
                expected_words.push_back(w);
            end
        endfunction

        task check_word(input logic [fbve_pkg::WORD_W-1:0] word, input logic last,
                        input logic range_error);
            t_word exp_w;
            if (expected_words.size() == 0) begin
                report($sformatf("unexpected word %h last %b", word, last));
                return;
            end
            exp_w = expected_words.pop_front();
            if (word !== exp_w.word) begin
                report($sformatf("word got %h want %h", word, exp_w.word));
            end
            if (last !== exp_w.last) begin
                report($sformatf("last got %b want %b", last, exp_w.last));
            end
            if (range_error !== exp_w.range_error) begin
                report($sformatf("range_error got %b want %b", range_error, exp_w.range_error));
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   burst_left;

    fbve_in_if  in_ch ();
    fbve_out_if out_ch ();
    fbve_cfg_if cfg_ch ();

    vector_scoreboard board;

    field_bit_vector_encoder #(
        .NUM_FIELDS          (FIELDS_MAX),
        .MAX_OUT_BITS        (OUT_BITS_MAX),
        .MAX_FIELD_CODE_BITS (CODE_BITS_MAX)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (rst_n && cfg_ch.valid && cfg_ch.ready) begin
            board.write_reg(cfg_ch.index, cfg_ch.data);
        end
    end

    always @(posedge clk) begin
        if (rst_n && in_ch.valid && in_ch.ready) begin
            board.note_values(in_ch.value_0, in_ch.value_1, in_ch.value_2, in_ch.value_3);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) begin
            board.check_word(out_ch.word, out_ch.last, out_ch.range_error);
        end
    end

    // receiver: short stalls, short grants and long stretches of steady ready
    initial begin : drain_side
        int hold;
        bit level;
        out_ch.ready <= 1'b0;
        hold = 0;
        level = 1'b0;
        forever begin
            @(posedge clk);
            if (hold == 0) begin
                case ($urandom_range(0, 9))
                    0: begin
                        level = 1'b1;
                        hold = $urandom_range(100, 600);
                    end
                    1, 2, 3: begin
                        level = 1'b0;
                        hold = $urandom_range(1, 12);
                    end
                    default: begin
                        level = 1'b1;
                        hold = $urandom_range(1, 6);
                    end
                endcase
            end
            hold--;
            out_ch.ready <= level;
        end
    end

    initial begin
        #300ms;
        $display("field_bit_vector_encoder verification failed");
        $finish;
    end

    function automatic logic [fbve_pkg::SETUP_W-1:0] make_setup(input int lo, input int hi,
                                                                input int en, input int ex);
        return {4'(ex), 3'(en), 16'(hi), 16'(lo)};
    endfunction

    function automatic logic [fbve_pkg::SETUP_W-1:0] random_setup();
        int lo, hi;
        case ($urandom_range(0, 7))
            0: begin
                lo = int'($signed(16'($urandom)));
                hi = int'($signed(16'($urandom)));
            end
            1: begin
                lo = -32768;
                hi = 32767;
            end
            2: begin
                lo = int'($urandom_range(0, 400)) - 200;
                hi = lo - int'($urandom_range(1, 50));
            end
            default: begin
                lo = int'($urandom_range(0, 400)) - 200;
                hi = lo + int'($urandom_range(0, 70));
            end
        endcase
        return make_setup(lo, hi, $urandom_range(0, 7),
                          ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                       : $urandom_range(0, 3));
    endfunction

    function automatic logic [fbve_pkg::VAL_W-1:0] pick_value(
        input logic [fbve_pkg::SETUP_W-1:0] s);
        int lo, hi;
        lo = int'($signed(s[15:0]));
        hi = int'($signed(s[31:16]));
        if (hi < lo) hi = lo;
        case ($urandom_range(0, 11))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2, 3:    return 16'($urandom);
            4:       return 16'(lo - int'($urandom_range(1, 4)));
            5:       return 16'(hi + int'($urandom_range(1, 4)));
            6:       return 16'(lo);
            7:       return 16'(hi);
            default: return 16'(lo + int'($urandom_range(0, hi - lo)));
        endcase
    endfunction

    task automatic send_values(input int a, b, c, d);
        int gap;
        if (burst_left == 0) begin
            case ($urandom_range(0, 5))
                0, 1:    gap = 0;
                2:       gap = $urandom_range(21, 400);
                default: gap = $urandom_range(1, 20);
            endcase
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 8);
        end
        in_ch.valid   <= 1'b1;
        in_ch.value_0 <= fbve_pkg::VAL_W'(a);
        in_ch.value_1 <= fbve_pkg::VAL_W'(b);
        in_ch.value_2 <= fbve_pkg::VAL_W'(c);
        in_ch.value_3 <= fbve_pkg::VAL_W'(d);
        do @(posedge clk); while (!in_ch.ready);
        burst_left--;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (board.expected_words.size() != 0) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [fbve_pkg::IDX_W-1:0] idx,
                             input logic [fbve_pkg::SETUP_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    task automatic program_regs(input int fc, input int ob,
                                input logic [fbve_pkg::SETUP_W-1:0] s0, s1, s2, s3);
        logic [fbve_pkg::SETUP_W-1:0] junk;
        junk = ($urandom_range(0, 1) == 1) ? fbve_pkg::SETUP_W'({$urandom, $urandom}) : '0;
        cfg_write(fbve_pkg::REG_FIELD_COUNT,
                  {junk[fbve_pkg::SETUP_W-1:fbve_pkg::FC_W], fbve_pkg::FC_W'(fc)});
        cfg_write(fbve_pkg::REG_OUTPUT_BITS,
                  {junk[fbve_pkg::SETUP_W-1:fbve_pkg::OB_W], fbve_pkg::OB_W'(ob)});
        cfg_write(fbve_pkg::REG_FIELD0_SETUP, s0);
        cfg_write(fbve_pkg::REG_FIELD0_SETUP + fbve_pkg::IDX_W'(1), s1);
        cfg_write(fbve_pkg::REG_FIELD0_SETUP + fbve_pkg::IDX_W'(2), s2);
        cfg_write(fbve_pkg::REG_FIELD0_SETUP + fbve_pkg::IDX_W'(3), s3);
        if ($urandom_range(0, 3) == 0) begin
            cfg_write(REG_SPARE_FIRST + fbve_pkg::IDX_W'($urandom_range(0, 1)),
                      fbve_pkg::SETUP_W'({$urandom, $urandom}));
        end
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_phase(input int items);
        logic [fbve_pkg::SETUP_W-1:0] s [fbve_pkg::PORTS];
        int fc, ob;
        case ($urandom_range(0, 11))
            0:       fc = 0;
            1:       fc = $urandom_range(5, 7);
            default: fc = $urandom_range(1, 4);
        endcase
        case ($urandom_range(0, 11))
            0:       ob = 0;
            1:       ob = $urandom_range(257, 511);
            2:       ob = 1;
            3:       ob = 64;
            default: ob = $urandom_range(1, 256);
        endcase
        foreach (s[i]) s[i] = random_setup();
        drain();
        program_regs(fc, ob, s[0], s[1], s[2], s[3]);
        repeat (items) begin
            send_values(pick_value(s[0]), pick_value(s[1]), pick_value(s[2]), pick_value(s[3]));
        end
    endtask

    initial begin
        board = new();
        burst_left = 0;
        rst_n <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.value_0 <= '0;
        in_ch.value_1 <= '0;
        in_ch.value_2 <= '0;
        in_ch.value_3 <= '0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.index  <= '0;
        cfg_ch.data   <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: one literal field, 0..1, full-length vector
        send_values(1, 0, 0, 0);
        send_values(5, 32767, -32768, 0);
        send_values(-32768, 32767, -1, 0);

        // one literal, Gray, thermometer and one-hot field, thermometer clipping and clamping both ways
        drain();
        program_regs(4, 256, make_setup(-32768, 32767, fbve_pkg::ENC_LITERAL, 1),
                     make_setup(-10, 20, fbve_pkg::ENC_GRAY, 2),
                     make_setup(0, 10, fbve_pkg::ENC_THERMO, 2),
                     make_setup(5, 12, fbve_pkg::ENC_ONE_HOT, 3));
        send_values(32767, 20, 10, 12);
        send_values(-32768, -10, 0, 5);
        send_values(0, 25, 15, 4);
        send_values(100, -11, -1, 8);

        // saturated field count, zero length, long codes, zero expansion
        drain();
        program_regs(7, 0, make_setup(-100, 300, fbve_pkg::ENC_LOG_THERMO, 0),
                     make_setup(3, 9, ENC_RSVD5, 1),
                     make_setup(-32768, 32767, fbve_pkg::ENC_THERMO, 15),
                     make_setup(-32768, 32767, fbve_pkg::ENC_ONE_HOT, 2));
        send_values(300, 9, 32767, -32768);
        send_values(-100, 3, 0, 32767);
        send_values(1000, 2, -32768, 0);

        drain();
        program_regs(4, 511, make_setup(-100, 300, fbve_pkg::ENC_LOG_THERMO, 0),
                     make_setup(3, 9, ENC_RSVD7, 1),
                     make_setup(-32768, 32767, fbve_pkg::ENC_THERMO, 15),
                     make_setup(-32768, 32767, ENC_RSVD6, 2));
        send_values(37, 9, 32767, -1);
        send_values(-101, 4, -32768, 32767);
        send_values(301, 10, 1, 0);

        // zero field count with inverted limits: empty code, all-zero vector
        drain();
        program_regs(0, 65, make_setup(7, -3, fbve_pkg::ENC_LITERAL, 1), random_setup(),
                     random_setup(), random_setup());
        send_values(7, 0, 0, 0);
        send_values(-3, -1, 1, 2);
        send_values(32767, 5, 5, 5);

        // a single-position code, an empty code and a high pass count
        drain();
        program_regs(2, 64, make_setup(0, 0, fbve_pkg::ENC_ONE_HOT, 15),
                     make_setup(-5, -5, fbve_pkg::ENC_THERMO, 0),
                     random_setup(), random_setup());
        send_values(0, -5, 0, 0);
        send_values(1, -6, 0, 0);

        repeat (10) random_phase(15);

        drain();
        repeat (600) @(posedge clk);
        if (board.errors == 0) begin
            $display("field_bit_vector_encoder verification clean");
        end else begin
            $display("field_bit_vector_encoder verification failed");
        end
        $finish;
    end

endmodule
